// ===== hw/rtl/can_bit_timing_search_assert.svh =====
// assertion macros of the bit-timing search checker
`ifndef CAN_BIT_TIMING_SEARCH_ASSERT_SVH
`define CAN_BIT_TIMING_SEARCH_ASSERT_SVH

// same-cycle implication under reset
`define CBTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbts check failed: same-cycle implication");

// next-cycle implication under reset
`define CBTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbts check failed: next-cycle implication");

`endif

// ===== hw/rtl/cbts_pkg.sv =====
// types and constants of the can bit-timing search
package cbts_pkg;

    // field widths
    localparam int CLK_W   = 27;
    localparam int BAUD_W  = 20;
    localparam int PDIV_W  = 4;
    localparam int WORD_W  = 15;

    // search ranges
    localparam int DIV_W   = 4;
    localparam int QNT_W   = 6;
    localparam int SEG_W   = 5;
    localparam int QD_W    = 10;
    localparam int PROD_W  = 14;

    localparam logic [DIV_W-1:0] DIV_MAX    = 4'd15;
    localparam logic [QNT_W-1:0] QUANTA_MIN = 6'd1;
    localparam logic [QNT_W-1:0] QUANTA_MAX = 6'd32;
    localparam logic [SEG_W-1:0] SEGS_MIN   = 5'd3;
    localparam logic [SEG_W-1:0] SEGS_MAX   = 5'd17;
    localparam logic [2:0]       SJW_MAX    = 3'd3;

    // main clock after reset
    localparam logic [CLK_W-1:0] CLK_RESET  = 27'd48000000;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SEARCH,
        ST_HOLD
    } t_state;

endpackage

// ===== hw/rtl/cbts_if.sv =====
// request and result channels of the can bit-timing search
interface cbts_in_if;
    import cbts_pkg::*;

    logic              valid;
    logic              ready;
    logic [BAUD_W-1:0] rate_bps;

    modport source (output valid, output rate_bps, input ready);
    modport sink   (input valid, input rate_bps, output ready);
endinterface

interface cbts_out_if;
    import cbts_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [PDIV_W-1:0] prescale_div;
    logic [WORD_W-1:0] bit_timing_word;

    modport source (output valid, output found, output prescale_div,
                    output bit_timing_word, input ready);
    modport sink   (input valid, input found, input prescale_div,
                    input bit_timing_word, output ready);
endinterface

// ===== hw/rtl/can_bit_timing_search.sv =====
// can bit-timing search: finds prescaler and segment timing for a bit rate
//
// i_in carries a requested bit rate (rate_bps); o_out returns one result per
// request: found, prescale_div and the packed bit_timing_word. i_cfg_we with
// i_cfg_wdata sets the main clock frequency; write it only while idle.
// A request is taken only in the idle state; the block then works on it alone.
// The clock-per-bit count comes from a shift-subtract divider and is loaded
// into a register; then one (divider, quanta, segments) candidate is checked
// per cycle by comparing the product of its three values with that count, up
// to 16*32*15 = 7680 candidates, until a hit or the last one. The result then
// passes through a hold state into the output register. A zero bit rate skips
// the divide and search and goes straight to the hold state. The sequencer
// returns to idle as the output register is filled, so a new request is taken
// only once the block is through with the last one.
// The result sits in an output register; the block returns to idle and takes
// the next request even while that result waits for o_out.ready. A second
// result stalls in a hold state until the output register frees up.
// Reset (synchronous, active low) empties the output register, returns the
// sequencer to idle and sets the main clock to 48 MHz.
module can_bit_timing_search (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    cbts_in_if.sink                    i_in,
    cbts_out_if.source                 o_out,
    input  logic                       i_cfg_we,
    input  logic [cbts_pkg::CLK_W-1:0] i_cfg_wdata
);
    import cbts_pkg::*;

    t_state r_state, n_state;

    logic [CLK_W-1:0]  r_main_clock_hz;
    logic [BAUD_W-1:0] r_baud;
    logic [CLK_W-1:0]  r_cycles;

    // search counters
    logic [DIV_W-1:0]  r_div;
    logic [QNT_W-1:0]  r_quanta;
    logic [SEG_W-1:0]  r_segs;
    logic [QD_W-1:0]   r_qd;
    logic [PROD_W-1:0] r_prod;

    // pending and output results
    logic              r_res_found;
    logic [PDIV_W-1:0] r_res_pdiv;
    logic [WORD_W-1:0] r_res_word;
    logic              r_out_valid;
    logic              r_out_found;
    logic [PDIV_W-1:0] r_out_pdiv;
    logic [WORD_W-1:0] r_out_word;

    // sequencer outputs
    logic in_ready;
    logic accept;
    logic div_start;
    logic search_step;
    logic hold_load;

    logic             div_done;
    logic [CLK_W-1:0] quotient;

    // candidate evaluation
    logic             hit;
    logic             seg_wrap;
    logic             qnt_wrap;
    logic             last;
    logic [4:0]       div_p1;
    logic [4:0]       div_p2;
    logic [QD_W-1:0]  qd_next;
    logic [PROD_W-1:0] prod_qd;
    logic [PROD_W-1:0] prod_div;
    logic [3:0]       rest;
    logic [2:0]       seg1;
    logic [2:0]       seg2;
    logic [1:0]       sjw;
    logic [WORD_W-1:0] hit_word;

    cbts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_main_clock_hz),
        .i_divisor  (r_baud),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // handshake
    assign accept = i_in.valid && in_ready;

    // candidate check and next candidate
    always_comb begin
        hit      = (r_cycles == {{(CLK_W-PROD_W){1'b0}}, r_prod});
        seg_wrap = (r_segs == SEGS_MAX);
        qnt_wrap = (r_quanta == QUANTA_MAX);
        last     = seg_wrap && qnt_wrap && (r_div == DIV_MAX);
        div_p1   = {1'b0, r_div} + 5'd1;
        div_p2   = {1'b0, r_div} + 5'd2;
        qd_next  = r_qd + QD_W'(div_p1);
        prod_qd  = PROD_W'({qd_next, 1'b0}) + PROD_W'(qd_next);
        prod_div = PROD_W'({div_p2, 1'b0}) + PROD_W'(div_p2);
    end

    // timing word of the current candidate
    always_comb begin
        rest     = 4'(r_segs - SEGS_MIN);
        seg1     = rest[3:1];
        seg2     = 3'(rest - {1'b0, seg1});
        sjw      = (seg1 > SJW_MAX) ? SJW_MAX[1:0] : seg1[1:0];
        hit_word = {seg2, 1'b0, seg1, sjw, 6'(r_quanta - QUANTA_MIN)};
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_in.rate_bps == '0) ? ST_HOLD : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (hit || last) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (hold_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        in_ready    = 1'b0;
        search_step = 1'b0;
        hold_load   = 1'b0;
        unique case (r_state)
            ST_IDLE:   in_ready    = 1'b1;
            ST_DIV:    ;
            ST_SEARCH: search_step = 1'b1;
            ST_HOLD:   hold_load   = !r_out_valid || o_out.ready;
            default:   ;
        endcase
        div_start = accept && (i_in.rate_bps != '0);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_out_valid     <= 1'b0;
            r_main_clock_hz <= CLK_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_main_clock_hz <= i_cfg_wdata;
            end
            if (hold_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture and search datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_baud      <= i_in.rate_bps;
            r_res_found <= 1'b0;
            r_res_pdiv  <= '0;
            r_res_word  <= '0;
        end
        if (div_done) begin
            r_cycles <= quotient;
            r_div    <= '0;
            r_quanta <= QUANTA_MIN;
            r_segs   <= SEGS_MIN;
            r_qd     <= QD_W'(1);
            r_prod   <= PROD_W'(SEGS_MIN);
        end
        if (search_step) begin
            if (hit) begin
                r_res_found <= 1'b1;
                r_res_pdiv  <= r_div;
                r_res_word  <= hit_word;
            end else if (seg_wrap && qnt_wrap) begin
                r_div    <= r_div + 1'b1;
                r_quanta <= QUANTA_MIN;
                r_segs   <= SEGS_MIN;
                r_qd     <= QD_W'(div_p2);
                r_prod   <= prod_div;
            end else if (seg_wrap) begin
                r_quanta <= r_quanta + 1'b1;
                r_segs   <= SEGS_MIN;
                r_qd     <= qd_next;
                r_prod   <= prod_qd;
            end else begin
                r_segs   <= r_segs + 1'b1;
                r_prod   <= r_prod + PROD_W'(r_qd);
            end
        end
        if (hold_load) begin
            r_out_found <= r_res_found;
            r_out_pdiv  <= r_res_pdiv;
            r_out_word  <= r_res_word;
        end
    end

    assign i_in.ready            = in_ready;
    assign o_out.valid           = r_out_valid;
    assign o_out.found           = r_out_found;
    assign o_out.prescale_div    = r_out_pdiv;
    assign o_out.bit_timing_word = r_out_word;

endmodule

// ===== hw/rtl/cbts_div.sv =====
// restoring divider, one quotient bit per cycle
module cbts_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [cbts_pkg::CLK_W-1:0] i_dividend,
    input  logic [cbts_pkg::BAUD_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [cbts_pkg::CLK_W-1:0] o_quotient
);
    import cbts_pkg::*;

    localparam int CNT_W = $clog2(CLK_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CLK_W - 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [BAUD_W-1:0] r_rem;
    logic [CLK_W-1:0]  r_quo;

    logic [BAUD_W:0]   rem_sh;
    logic [BAUD_W:0]   diff;
    logic              ge;

    // one shift-subtract step
    always_comb begin
        rem_sh = {r_rem, r_quo[CLK_W-1]};
        diff   = rem_sh - {1'b0, i_divisor};
        ge     = (rem_sh >= {1'b0, i_divisor});
    end

    // control
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
        end else if (r_busy && r_cnt == CNT_LAST) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[BAUD_W-1:0] : rem_sh[BAUD_W-1:0];
            r_quo <= {r_quo[CLK_W-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hw/rtl/cbts_checker.sv =====
// port-level checker for the can bit-timing search, with its bind
`include "can_bit_timing_search_assert.svh"

module cbts_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_found,
    input logic [cbts_pkg::PDIV_W-1:0] i_prescale_div,
    input logic [cbts_pkg::WORD_W-1:0] i_bit_timing_word
);
    import cbts_pkg::*;

    // a stalled result stays offered
    `CBTS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // the block is busy right after taking a request
    `CBTS_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // a miss carries all-zero timing
    `CBTS_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, i_out_valid && !i_found, i_prescale_div == '0 && i_bit_timing_word == '0)

    // a hit splits segments evenly, seg2 at most one above seg1
    `CBTS_ASSERT_IMP(a_seg_split, i_clk, i_rst_n, i_out_valid && i_found, !i_bit_timing_word[11] && (i_bit_timing_word[14:12] == i_bit_timing_word[10:8] || i_bit_timing_word[14:12] == i_bit_timing_word[10:8] + 3'd1))

endmodule

bind can_bit_timing_search cbts_checker u_cbts_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_found           (o_out.found),
    .i_prescale_div    (o_out.prescale_div),
    .i_bit_timing_word (o_out.bit_timing_word)
);
